// ===== src/dcn_pkg.sv =====
// ============================================================================
// dcn_pkg: shared definitions for the Chinese numeral speller
// Symbol codes, datapath command and status bundles, and sizing helpers.
// ============================================================================
package dcn_pkg;

    localparam int DEF_VALUE_BITS = 31;
    localparam int CODE_W         = 4;
    localparam int BIG_W          = 2;
    localparam int POS_W          = 2;

    localparam logic [CODE_W-1:0] SYM_ZERO = 4'd0;
    localparam logic [CODE_W-1:0] SYM_ONE  = 4'd1;
    localparam logic [CODE_W-1:0] SYM_TEN  = 4'd10;
    localparam logic [CODE_W-1:0] SYM_BIG  = 4'd13;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_DIGIT,
        SEL_UNIT,
        SEL_BIG
    } sym_sel_t;

    typedef struct packed {
        logic             load;
        logic             dabble;
        logic             shift;
        logic             emit;
        sym_sel_t         sel;
        logic [POS_W-1:0] unit_pos;
        logic [BIG_W-1:0] big_code;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic cur_zero;
        logic cur_one;
        logic rest_nz;
        logic out_free;
    } dp_status_t;

    // Number of four-digit groups needed for a binary value of the given width.
    // The digit count uses log10(2) rounded up slightly, so it never falls short.
    function automatic int groups_for(input int bits);
        return ((bits * 30103) / 100000 + 4) / 4;
    endfunction

endpackage

// ===== src/decimal_to_chinese_numeral.sv =====
// ============================================================================
// decimal_to_chinese_numeral: spells a binary integer as Chinese numerals
// Takes one unsigned number per request and returns its spelling as a run
// of symbol requests, most significant first, the final one with is_last.
//
// Input channel: number_value with number_valid / number_stall. A request
// is taken when number_valid is high and number_stall is low; number_stall
// stays high from the cycle after acceptance until the last symbol of that
// number has been loaded into the output register.
// Output channel: symbol_code, big_unit, is_last with symbol_valid /
// symbol_stall. One output register holds the next symbol; it keeps its
// value while symbol_stall is high, and the sequencer waits on it.
// Sequence: the BCD conversion runs first, one bit a cycle, then the
// digits are scanned top down and each symbol is written to the output
// register, stopping at the last symbol; output stalls hold the scan.
// The next number is taken in the cycle after the last symbol is loaded,
// so a new number is not taken until the current one is fully spelled.
// Reset clears the sequencer and the output valid; no clearing pass.
// ============================================================================
module decimal_to_chinese_numeral #(
    parameter int VALUE_BITS = dcn_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          number_valid,
    output logic                          number_stall,
    input  logic [VALUE_BITS-1:0]         number_value,
    output logic                          symbol_valid,
    input  logic                          symbol_stall,
    output logic [dcn_pkg::CODE_W-1:0]    symbol_code,
    output logic [dcn_pkg::BIG_W-1:0]     big_unit,
    output logic                          is_last
);

    dcn_pkg::dp_cmd_t    cmd;
    dcn_pkg::dp_status_t status;

    dcn_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .status       (status),
        .cmd          (cmd)
    );

    dcn_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_value (number_value),
        .cmd          (cmd),
        .status       (status),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol_code  (symbol_code),
        .big_unit     (big_unit),
        .is_last      (is_last)
    );

    // A symbol is only written when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("symbol written over a pending output");

    // After a request is taken the sequencer must be busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (number_valid && !number_stall) |=> number_stall)
        else $error("input not held off while converting");

    // Writing the final symbol returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> !number_stall)
        else $error("sequencer did not finish after final symbol");

endmodule

// ===== src/dcn_datapath.sv =====
// ============================================================================
// dcn_datapath: conversion and symbol datapath
// Binary to BCD by shift-and-add-3, a digit shifter that presents the most
// significant unscanned digit, and the registered symbol output.
// ============================================================================
module dcn_datapath #(
    parameter int VALUE_BITS = dcn_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [VALUE_BITS-1:0]         number_value,
    input  dcn_pkg::dp_cmd_t              cmd,
    output dcn_pkg::dp_status_t           status,
    output logic                          symbol_valid,
    input  logic                          symbol_stall,
    output logic [dcn_pkg::CODE_W-1:0]    symbol_code,
    output logic [dcn_pkg::BIG_W-1:0]     big_unit,
    output logic                          is_last
);

    localparam int GROUPS = dcn_pkg::groups_for(VALUE_BITS);
    localparam int DIGITS = GROUPS * 4;
    localparam int BCD_W  = DIGITS * 4;

    logic [VALUE_BITS-1:0]         bin_reg, bin_next;
    logic [BCD_W-1:0]              bcd_reg, bcd_next;
    logic [BCD_W-1:0]              corr;
    logic [3:0]                    cur_digit;
    logic                          valid_reg, valid_next;
    logic [dcn_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [dcn_pkg::BIG_W-1:0]     big_reg, big_next;
    logic                          last_reg, last_next;

    assign cur_digit = bcd_reg[BCD_W-1 -: 4];

    assign status.cur_zero = (cur_digit == 4'd0);
    assign status.cur_one  = (cur_digit == dcn_pkg::SYM_ONE);
    assign status.rest_nz  = |bcd_reg[BCD_W-5:0];
    assign status.out_free = !valid_reg || !symbol_stall;

    // Add-3 correction on every digit ahead of the next doubling.
    always_comb
    begin
        logic [3:0] d;
        d    = '0;
        corr = '0;
        for (int k = 0; k < DIGITS; k++)
        begin
            d = bcd_reg[4*k +: 4];
            corr[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            bin_next = number_value;
            bcd_next = '0;
        end
        else if (cmd.dabble)
        begin
            bcd_next = {corr[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        code_next  = code_reg;
        big_next   = big_reg;
        last_next  = last_reg;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
            last_next  = cmd.last;
            big_next   = '0;
            case (cmd.sel)
                dcn_pkg::SEL_ZERO:  code_next = dcn_pkg::SYM_ZERO;
                dcn_pkg::SEL_DIGIT: code_next = cur_digit;
                dcn_pkg::SEL_UNIT:
                    code_next = dcn_pkg::SYM_TEN + dcn_pkg::CODE_W'(cmd.unit_pos)
                                - dcn_pkg::CODE_W'(1);
                dcn_pkg::SEL_BIG:
                begin
                    code_next = dcn_pkg::SYM_BIG;
                    big_next  = cmd.big_code;
                end
                default:            code_next = dcn_pkg::SYM_ZERO;
            endcase
        end
        else if (valid_reg && !symbol_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        code_reg <= code_next;
        big_reg  <= big_next;
        last_reg <= last_next;
    end

    assign symbol_valid = valid_reg;
    assign symbol_code  = code_reg;
    assign big_unit     = big_reg;
    assign is_last      = last_reg;

endmodule

// ===== src/dcn_ctrl.sv =====
// ============================================================================
// dcn_ctrl: sequencer for the Chinese numeral speller
// Runs the BCD conversion, then walks the digits from the top and decides
// which symbols each digit and each group produce.
// ============================================================================
module dcn_ctrl #(
    parameter int VALUE_BITS = dcn_pkg::DEF_VALUE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 number_valid,
    output logic                 number_stall,
    input  dcn_pkg::dp_status_t  status,
    output dcn_pkg::dp_cmd_t     cmd
);

    localparam int GROUPS = dcn_pkg::groups_for(VALUE_BITS);
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_ZERO,
        ST_DIGIT,
        ST_UNIT,
        ST_BIG,
        ST_ZERO_VALUE
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [GRP_W-1:0]          grp_reg, grp_next;
    logic [dcn_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      started_reg, started_next;
    logic                      zero_run_reg, zero_run_next;
    logic                      group_nz_reg, group_nz_next;
    logic                      grp_bottom;
    logic                      unit_last;

    assign grp_bottom   = (grp_reg == '0);
    // A unit, or a digit in the ones place, ends the spelling when nothing
    // nonzero lies below it and no big unit follows.
    assign unit_last    = grp_bottom && !status.rest_nz;
    assign number_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        grp_next      = grp_reg;
        pos_next      = pos_reg;
        started_next  = started_reg;
        zero_run_next = zero_run_reg;
        group_nz_next = group_nz_reg;
        cmd           = '0;
        cmd.sel       = dcn_pkg::SEL_ZERO;
        cmd.unit_pos  = pos_reg;
        cmd.big_code  = dcn_pkg::BIG_W'(grp_reg - GRP_W'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (number_valid)
                begin
                    cmd.load      = 1'b1;
                    cnt_next      = CNT_W'(VALUE_BITS - 1);
                    grp_next      = GRP_W'(GROUPS - 1);
                    pos_next      = '1;
                    started_next  = 1'b0;
                    zero_run_next = 1'b0;
                    group_nz_next = 1'b0;
                    state_next    = ST_CONVERT;
                end
            end

            ST_CONVERT:
            begin
                cmd.dabble = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            ST_SCAN:
            begin
                if (status.cur_zero)
                begin
                    if (started_reg)
                    begin
                        zero_run_next = 1'b1;
                    end
                    if (pos_reg != '0)
                    begin
                        cmd.shift = 1'b1;
                        pos_next  = pos_reg - dcn_pkg::POS_W'(1);
                    end
                    else if (group_nz_reg && !grp_bottom)
                    begin
                        state_next = ST_BIG;
                    end
                    else if (grp_bottom)
                    begin
                        state_next = started_reg ? ST_IDLE : ST_ZERO_VALUE;
                    end
                    else
                    begin
                        cmd.shift = 1'b1;
                        pos_next  = '1;
                        grp_next  = grp_reg - GRP_W'(1);
                    end
                end
                else
                begin
                    started_next  = 1'b1;
                    group_nz_next = 1'b1;
                    // A spelling that would open with "one ten" opens with "ten".
                    if (!started_reg && status.cur_one && pos_reg == dcn_pkg::POS_W'(1))
                    begin
                        state_next = ST_UNIT;
                    end
                    else if (started_reg && zero_run_reg)
                    begin
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end

            ST_ZERO:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = dcn_pkg::SEL_ZERO;
                    zero_run_next = 1'b0;
                    state_next    = ST_DIGIT;
                end
            end

            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = dcn_pkg::SEL_DIGIT;
                    cmd.last = (pos_reg == '0) && unit_last;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pos_reg != '0)
                    begin
                        state_next = ST_UNIT;
                    end
                    else
                    begin
                        state_next = ST_BIG;
                    end
                end
            end

            ST_UNIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = dcn_pkg::SEL_UNIT;
                    cmd.last = unit_last;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.shift  = 1'b1;
                        pos_next   = pos_reg - dcn_pkg::POS_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_BIG:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = dcn_pkg::SEL_BIG;
                    cmd.last = !status.rest_nz;
                    // Trailing zeros of a nonzero group never produce a zero symbol.
                    zero_run_next = 1'b0;
                    group_nz_next = 1'b0;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.shift  = 1'b1;
                        pos_next   = '1;
                        grp_next   = grp_reg - GRP_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_ZERO_VALUE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = dcn_pkg::SEL_ZERO;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            grp_reg      <= '0;
            pos_reg      <= '0;
            started_reg  <= 1'b0;
            zero_run_reg <= 1'b0;
            group_nz_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            grp_reg      <= grp_next;
            pos_reg      <= pos_next;
            started_reg  <= started_next;
            zero_run_reg <= zero_run_next;
            group_nz_reg <= group_nz_next;
        end
    end

endmodule

// ===== verif/decimal_to_chinese_numeral_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// decimal_to_chinese_numeral_tb: self-checking bench for the numeral speller
// Sends directed and random numbers through the request channel and checks
// every symbol that comes back against a local spelling predictor or a typed
// row spelling. Sender and sink both pause at random, with quiet stretches.
// ============================================================================
module decimal_to_chinese_numeral_tb;

    localparam int VALUE_BITS  = dcn_pkg::DEF_VALUE_BITS;
    localparam int CODE_W      = dcn_pkg::CODE_W;
    localparam int BIG_W       = dcn_pkg::BIG_W;
    localparam int DIRECTED_N  = 25;
    localparam int RANDOM_N    = 185;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 120;

    localparam logic [BIG_W-1:0] NOT_BIG = 2'd0;
    localparam logic [BIG_W-1:0] BIG_WAN = 2'd0;
    localparam logic [BIG_W-1:0] BIG_YI  = 2'd1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BIG_W-1:0]  big;
        logic              last;
    } numeral_sym_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BIG_W-1:0]  big;
    } sym_word_t;

    // A row with typed_n of zero is checked against the predictor; otherwise
    // its spelling is the one or two symbols typed into the row.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [1:0]            typed_n;
        sym_word_t             first_sym;
        sym_word_t             second_sym;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  number_valid;
    logic                  number_stall;
    logic [VALUE_BITS-1:0] number_value;
    logic                  symbol_valid;
    logic                  symbol_stall;
    logic [CODE_W-1:0]     symbol_code;
    logic [BIG_W-1:0]      big_unit;
    logic                  is_last;

    numeral_sym_t expected_syms[$];
    numeral_sym_t want_sym;
    stim_row_t    directed_rows [DIRECTED_N];
    int           fail_count  = 0;
    int           idle_cycles = 0;
    int           sink_hold   = 0;
    int           sink_cycle  = 0;

    decimal_to_chinese_numeral #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .number_value (number_value),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol_code  (symbol_code),
        .big_unit     (big_unit),
        .is_last      (is_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Spells one value and queues its symbols, most significant first.
    function automatic void spell_value(input logic [VALUE_BITS-1:0] value);
        numeral_sym_t    spelled[$];
        numeral_sym_t    one_sym;
        logic [CODE_W-1:0] gcode[8];
        longint unsigned rest;
        int unsigned     gv;
        int unsigned     d;
        int              k;
        int              i;
        int              glen;
        rest = 64'(value);
        if (rest == 0)
            spelled.push_front('{dcn_pkg::SYM_ZERO, NOT_BIG, 1'b0});
        else
        begin
            for (k = 0; k < 4 && rest > 0; k++)
            begin
                gv   = 32'(rest % 10000);
                rest = rest / 10000;
                if (gv > 0)
                begin
                    // Digits of the group are gathered low to high, then
                    // pushed to the front so they come out high to low.
                    glen = 0;
                    for (i = 0; i < 4; i++)
                    begin
                        d  = gv % 10;
                        gv = gv / 10;
                        if (d > 0)
                        begin
                            if (i > 0)
                            begin
                                gcode[glen] = CODE_W'(dcn_pkg::SYM_TEN + i - 1);
                                glen++;
                            end
                            gcode[glen] = CODE_W'(d);
                            glen++;
                        end
                        else if (glen > 0 && gcode[glen-1] != dcn_pkg::SYM_ZERO)
                        begin
                            gcode[glen] = dcn_pkg::SYM_ZERO;
                            glen++;
                        end
                    end
                    if (k > 0)
                        spelled.push_front('{dcn_pkg::SYM_BIG, BIG_W'(k - 1), 1'b0});
                    for (i = 0; i < glen; i++)
                        spelled.push_front('{gcode[i], NOT_BIG, 1'b0});
                end
                else if (k > 0 && spelled.size() > 0 &&
                         spelled[0].code != dcn_pkg::SYM_ZERO)
                    spelled.push_front('{dcn_pkg::SYM_ZERO, NOT_BIG, 1'b0});
            end
            // The top group never starts with a zero, and a leading
            // "one ten" is said as plain "ten".
            if (spelled.size() > 1 && spelled[0].code == dcn_pkg::SYM_ZERO)
                spelled.delete(0);
            if (spelled.size() > 1 && spelled[0].code == dcn_pkg::SYM_ONE &&
                spelled[1].code == dcn_pkg::SYM_TEN)
                spelled.delete(0);
        end
        for (i = 0; i < spelled.size(); i++)
        begin
            one_sym      = spelled[i];
            one_sym.last = (i == spelled.size() - 1);
            expected_syms.push_back(one_sym);
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        logic [31:0]     raw;
        longint unsigned v;
        longint unsigned scale;
        int              style;
        int              digits;
        int              i;
        style = $urandom_range(0, 9);
        raw   = $urandom();
        if (style < 3)
            return raw[VALUE_BITS-1:0];
        if (style < 5)
            return VALUE_BITS'($urandom_range(0, 120));
        if (style == 9)
        begin
            // Leading "one ten" in the top group, with or without lower digits.
            case ($urandom_range(0, 2))
                0:       scale = 1;
                1:       scale = 10000;
                default: scale = 100000000;
            endcase
            v = $urandom_range(10, 19) * scale;
            if ($urandom_range(0, 1) && scale > 1)
                v = v + $urandom_range(0, int'(scale - 1));
            return v[VALUE_BITS-1:0];
        end
        // Sparse decimal digits, so that zero runs and empty groups are common.
        digits = $urandom_range(1, 10);
        v      = 0;
        for (i = 0; i < digits; i++)
            v = v * 10 + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0);
        while (v > 64'd2147483647)
            v = v / 10;
        return v[VALUE_BITS-1:0];
    endfunction

    // Offers one number, after a pause when gap is nonzero, and returns at the
    // falling edge that follows its acceptance.
    task automatic send_number(input logic [VALUE_BITS-1:0] value, input int gap);
        if (gap > 0)
        begin
            number_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        number_value <= value;
        number_valid <= 1'b1;
        @(posedge clk);
        while (number_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        number_valid = 1'b0;
        number_value = '0;
        directed_rows = '{
            '{31'd0,          2'd1, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd1,          2'd1, '{dcn_pkg::SYM_ONE,  NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd10,         2'd1, '{dcn_pkg::SYM_TEN,  NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd10000,      2'd2, '{dcn_pkg::SYM_ONE,  NOT_BIG},
                                    '{dcn_pkg::SYM_BIG,  BIG_WAN}},
            '{31'd100000000,  2'd2, '{dcn_pkg::SYM_ONE,  NOT_BIG},
                                    '{dcn_pkg::SYM_BIG,  BIG_YI}},
            '{31'd9,          2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd11,         2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd19,         2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd20,         2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd100,        2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd101,        2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd110,        2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd1001,       2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd1010,       2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd10001,      2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd100001,     2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd1000000,    2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd10000000,   2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd100000001,  2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd100010000,  2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd99999999,   2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd1234567890, 2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd2000000000, 2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd1073741824, 2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}},
            '{31'd2147483647, 2'd0, '{dcn_pkg::SYM_ZERO, NOT_BIG},
                                    '{dcn_pkg::SYM_ZERO, NOT_BIG}}
        };
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIRECTED_N; r++)
        begin
            send_number(directed_rows[r].value, (r % 4 == 3) ? pick_gap() : 0);
            if (directed_rows[r].typed_n == 2'd0)
                spell_value(directed_rows[r].value);
            else
            begin
                expected_syms.push_back('{directed_rows[r].first_sym.code,
                                          directed_rows[r].first_sym.big,
                                          directed_rows[r].typed_n == 2'd1});
                if (directed_rows[r].typed_n == 2'd2)
                    expected_syms.push_back('{directed_rows[r].second_sym.code,
                                              directed_rows[r].second_sym.big, 1'b1});
            end
        end

        for (int n = 0; n < RANDOM_N; n++)
        begin
            logic [VALUE_BITS-1:0] value;
            value = rand_value();
            // Every third block of requests goes back to back.
            send_number(value, ((n / 25) % 3 == 1) ? 0 : pick_gap());
            spell_value(value);
        end
        number_valid <= 1'b0;

        while (expected_syms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Symbol sink back-pressure, with a quiet stretch every fourth window.
    initial
    begin
        symbol_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            sink_cycle++;
            if (sink_hold > 0)
            begin
                symbol_stall <= 1'b1;
                sink_hold--;
            end
            else if ((sink_cycle / 256) % 4 == 3)
                symbol_stall <= 1'b0;
            else
            begin
                sink_hold = pick_gap();
                symbol_stall <= (sink_hold > 0);
                if (sink_hold > 0)
                    sink_hold--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && symbol_valid && !symbol_stall)
        begin
            if (expected_syms.size() == 0)
            begin
                $error("symbol_code: expected none, got %0d", symbol_code);
                fail_count++;
            end
            else
            begin
                want_sym = expected_syms.pop_front();
                if (symbol_code !== want_sym.code)
                begin
                    $error("symbol_code: expected %0d, got %0d", want_sym.code, symbol_code);
                    fail_count++;
                end
                if (big_unit !== want_sym.big)
                begin
                    $error("big_unit: expected %0d, got %0d", want_sym.big, big_unit);
                    fail_count++;
                end
                if (is_last !== want_sym.last)
                begin
                    $error("is_last: expected %0d, got %0d", want_sym.last, is_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (number_valid && !number_stall) || (symbol_valid && !symbol_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== files.f =====
src/dcn_pkg.sv
src/dcn_datapath.sv
src/dcn_ctrl.sv
src/decimal_to_chinese_numeral.sv
verif/decimal_to_chinese_numeral_tb.sv
